// File: design/itrt_pkg.sv
// shared constants, types and helpers for the radix text unit
package itrt_pkg;

  localparam int unsigned RADIX_W = 6;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CHAR_W  = 7;

  // quotient bits resolved per divider cycle
  localparam int unsigned DIV_STEPS = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

  localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;
  localparam logic [CHAR_W-1:0]  DIGIT_TEN  = 7'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;
  localparam logic [CHAR_W-1:0] ASCII_Z     = 7'h5A;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

  // per-job control travelling with the magnitude
  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic               minus;
  } job_ctl_t;

  // digit value to its ascii code, capitals above nine
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DIGIT_NINE) begin
      c = ASCII_A + CHAR_W'(d) - DIGIT_TEN;
    end else begin
      c = ASCII_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

// File: design/integer_to_radix_text_unit.sv
// Integer to radix text converter. Each accepted request is a signed
// VALUE_BITS-bit number; it comes out as ASCII characters, most significant
// digit first, with out_last_char on the final one. The radix register
// (cfg_data, 2..36, reset 10, values outside are clamped) selects the base;
// a minus sign leads only in radix ten, other bases give the bare magnitude,
// and zero gives a single '0'. Every digit comes from the shared remainder
// divider, which resolves eight quotient bits per cycle, and every
// character passes through the registered read port of the digit stack.
// A two-entry queue lets the input side take further requests while a
// conversion runs or a character waits.
module integer_to_radix_text_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [itrt_pkg::RADIX_W-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_BITS-1:0]  in_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [itrt_pkg::CHAR_W-1:0]   out_character,
  output logic                          out_last_char
);
  import itrt_pkg::*;

  logic                  push_valid;
  logic                  push_ready;
  logic [VALUE_BITS-1:0] push_mag;
  job_ctl_t              push_ctl;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [VALUE_BITS-1:0] pop_mag;
  job_ctl_t              pop_ctl;

  // intake and classification
  itrt_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_number  (in_number),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_mag   (push_mag),
    .push_ctl   (push_ctl)
  );

  // decoupling queue
  itrt_queue #(.VALUE_BITS(VALUE_BITS)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_mag   (push_mag),
    .push_ctl   (push_ctl),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_mag    (pop_mag),
    .pop_ctl    (pop_ctl)
  );

  // conversion and emission
  itrt_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_mag       (pop_mag),
    .pop_ctl       (pop_ctl),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last_char (out_last_char)
  );

endmodule

// File: design/itrt_front.sv
// front end: radix register, request intake and sign/magnitude split
module itrt_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [itrt_pkg::RADIX_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [VALUE_BITS-1:0] in_number,
  output logic                       push_valid,
  input  logic                       push_ready,
  output logic [VALUE_BITS-1:0]      push_mag,
  output itrt_pkg::job_ctl_t         push_ctl
);
  import itrt_pkg::*;

  logic [RADIX_W-1:0]    radix_r;
  logic [RADIX_W-1:0]    radix_nxt;
  logic [RADIX_W-1:0]    radix_eff;
  logic [VALUE_BITS-1:0] raw;
  logic                  negative;

  // radix register, always writable
  assign cfg_ready = 1'b1;
  assign radix_nxt = (cfg_valid && cfg_ready) ? cfg_data : radix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  // clamp radix into the supported range
  always_comb begin
    if (radix_r < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_r;
    end
  end

  // magnitude; the most negative value maps onto 2^(VALUE_BITS-1) unchanged
  assign raw      = VALUE_BITS'(unsigned'(in_number));
  assign negative = raw[VALUE_BITS-1];
  assign push_mag = negative ? (~raw + VALUE_BITS'(1)) : raw;

  // minus sign only in decimal
  assign push_ctl.radix = radix_eff;
  assign push_ctl.minus = negative && (radix_eff == RADIX_DEC);

  assign push_valid = in_valid;
  assign in_stall   = !push_ready;

endmodule

// File: design/itrt_queue.sv
// two-entry job queue between front and back
module itrt_queue #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  logic [VALUE_BITS-1:0] push_mag,
  input  itrt_pkg::job_ctl_t    push_ctl,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output logic [VALUE_BITS-1:0] pop_mag,
  output itrt_pkg::job_ctl_t    pop_ctl
);
  import itrt_pkg::*;

  logic [VALUE_BITS-1:0] mag_q_r [2];
  job_ctl_t              ctl_q_r [2];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            count_r, count_nxt;
  logic                  push_fire;
  logic                  pop_fire;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  assign pop_mag = mag_q_r[rd_ptr_r];
  assign pop_ctl = ctl_q_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push_fire ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_fire ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 2'd1;
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mag_q_r[wr_ptr_r] <= push_mag;
      ctl_q_r[wr_ptr_r] <= push_ctl;
    end
  end

endmodule

// File: design/itrt_back.sv
// back end: radix divider, digit stack and character output register
module itrt_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  logic [VALUE_BITS-1:0]       pop_mag,
  input  itrt_pkg::job_ctl_t          pop_ctl,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [itrt_pkg::CHAR_W-1:0] out_character,
  output logic                        out_last_char
);
  import itrt_pkg::*;

  localparam int CHUNKS  = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int PAD_W   = CHUNKS * DIV_STEPS;
  localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int PTR_W   = $clog2(VALUE_BITS);
  localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(CHUNKS - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_SIGN  = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_SHOW  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [PAD_W-1:0]     div_r, div_nxt;
  logic [DIGIT_W-1:0]   rem_r, rem_nxt;
  logic [RADIX_W-1:0]   radix_r, radix_nxt;
  logic                 minus_r, minus_nxt;
  logic [CHUNK_W-1:0]   chunk_r, chunk_nxt;
  logic [PTR_W-1:0]     ptr_r, ptr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [DIGIT_W-1:0]   digit_mem [VALUE_BITS];
  logic [DIGIT_W-1:0]   rd_data_r;
  logic                 mem_we;
  logic [PAD_W-1:0]     step_div;
  logic [DIGIT_W-1:0]   step_rem;
  logic                 out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign pop_ready = (state_r == ST_IDLE);

  // eight restoring division steps per cycle
  always_comb begin
    logic [DIGIT_W:0]   t;
    logic [DIGIT_W-1:0] r;
    logic [PAD_W-1:0]   d;
    r = rem_r;
    d = div_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r, d[PAD_W-1]};
      d = {d[PAD_W-2:0], 1'b0};
      if (t >= {1'b0, radix_r}) begin
        t    = t - {1'b0, radix_r};
        d[0] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    step_div = d;
    step_rem = r;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    radix_nxt     = radix_r;
    minus_nxt     = minus_r;
    chunk_nxt     = chunk_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          div_nxt   = PAD_W'(pop_mag);
          rem_nxt   = '0;
          radix_nxt = pop_ctl.radix;
          minus_nxt = pop_ctl.minus;
          chunk_nxt = '0;
          ptr_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        div_nxt = step_div;
        rem_nxt = step_rem;
        if (chunk_r == CHUNK_LAST) begin
          // one digit done: push it, restart on the quotient
          mem_we    = 1'b1;
          rem_nxt   = '0;
          chunk_nxt = '0;
          if (step_div == '0) begin
            state_nxt = minus_r ? ST_SIGN : ST_FETCH;
          end else begin
            ptr_nxt = ptr_r + PTR_W'(1);
          end
        end else begin
          chunk_nxt = chunk_r + CHUNK_W'(1);
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        // digits leave the stack most significant first
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_to_ascii(rd_data_r);
          out_last_nxt  = (ptr_r == '0);
          if (ptr_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt   = ptr_r - PTR_W'(1);
            state_nxt = ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    radix_r    <= radix_nxt;
    minus_r    <= minus_nxt;
    chunk_r    <= chunk_nxt;
    ptr_r      <= ptr_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // digit stack, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[ptr_r] <= step_rem;
    end
    rd_data_r <= digit_mem[ptr_r];
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last_char = out_last_r;

endmodule

// File: design/itrt_checker.sv
// port-level checks for the radix text unit, with its bind
module itrt_checker #(
  parameter int VALUE_BITS = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic signed [VALUE_BITS-1:0]  in_number,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [itrt_pkg::CHAR_W-1:0]   out_character,
  input logic                          out_last_char
);
  import itrt_pkg::*;

  // a stalled request stays offered unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_number))
    else $error("stalled request changed");

  // a held character does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_character)
      && $stable(out_last_char))
    else $error("stalled character changed");

  // only digits, capitals and the minus sign appear
  a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character >= ASCII_ZERO && out_character <= ASCII_NINE)
      || (out_character >= ASCII_A && out_character <= ASCII_Z)
      || (out_character == ASCII_MINUS))
    else $error("illegal character code");

  // a sign never ends a text
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_character == ASCII_MINUS) |-> !out_last_char)
    else $error("minus sign marked last");

  // a digit follows a sign, never a second sign straight away
  a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_character == ASCII_MINUS)
      |=> !(out_valid && (out_character == ASCII_MINUS)))
    else $error("two minus signs in a row");

endmodule

bind integer_to_radix_text_unit itrt_checker #(.VALUE_BITS(VALUE_BITS)) u_itrt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_number     (in_number),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_character (out_character),
  .out_last_char (out_last_char)
);
